// ----- src/ert_pkg.sv -----
// ----------------------------------------------------------------------------
// ert_pkg
// Opcodes, status codes and the per-cell control word of the edge record table.
// ----------------------------------------------------------------------------
package ert_pkg;

  localparam int OP_W  = 3;
  localparam int ST_W  = 2;
  localparam int STN_W = 16;
  localparam int ID_W  = 16;
  localparam int CNT_W = 6;

  localparam logic [OP_W-1:0] OP_ADD          = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE       = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP       = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND_FROM    = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND_TO      = 3'd4;
  localparam logic [OP_W-1:0] OP_FIND_BETWEEN = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd3;

  // Per-cell control: rotate moves the whole chain one place toward cell 0,
  // compact pulls from the upper neighbor, load takes the new record.
  typedef struct packed {
    logic rotate;
    logic compact;
    logic load;
  } ert_cell_ctl_t;

endpackage

// ----- src/ert_cell.sv -----
// ----------------------------------------------------------------------------
// ert_cell
// One table slot: holds id and endpoints, takes its upper neighbor's record
// on rotate or compact, or a new record on load.
// ----------------------------------------------------------------------------
module ert_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                       clk,
  input  ert_pkg::ert_cell_ctl_t     ctl,
  input  logic [KEY_BITS-1:0]        nbr_id,
  input  logic [ert_pkg::STN_W-1:0]  nbr_start,
  input  logic [ert_pkg::STN_W-1:0]  nbr_end,
  input  logic [KEY_BITS-1:0]        new_id,
  input  logic [ert_pkg::STN_W-1:0]  new_start,
  input  logic [ert_pkg::STN_W-1:0]  new_end,
  output logic [KEY_BITS-1:0]        id_r,
  output logic [ert_pkg::STN_W-1:0]  start_r,
  output logic [ert_pkg::STN_W-1:0]  end_r
);

  always_ff @(posedge clk) begin
    if (ctl.rotate || ctl.compact) begin
      id_r    <= nbr_id;
      start_r <= nbr_start;
      end_r   <= nbr_end;
    end else if (ctl.load) begin
      id_r    <= new_id;
      start_r <= new_start;
      end_r   <= new_end;
    end
  end

endmodule

// ----- src/edge_record_table.sv -----
// ----------------------------------------------------------------------------
// edge_record_table
// Ordered table of edge records (id, start station, end station) kept in a
// chain of cells that rotates once per defined operation.
// ----------------------------------------------------------------------------
// Usage: one input word carries an opcode, two stations and an edge key.
// The block takes a word only while idle (in_stall low). Every defined
// operation rotates the cell chain TABLE_DEPTH times, presenting each entry
// in turn at cell 0 where it is compared, then builds the final word: add
// writes the new record into the slot at the fill count, remove pulls every
// later cell down one place at once. A new word is taken only after the
// final word of the previous operation is issued; undefined opcodes skip
// the rotation and go straight to the final word.
// Searches emit one word per match, in table order, then a count word with
// last set; every other operation emits one word with last set.
// The result sits in an output register; a stall on out_stall pauses the
// rotation only when a match word has nowhere to go, so a finished word may
// wait while the next input word is already accepted.
// Reset empties the table (fill count zero) and drops any pending result.
// ----------------------------------------------------------------------------
module edge_record_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ert_pkg::OP_W-1:0]    in_opcode,
  input  logic [ert_pkg::STN_W-1:0]   in_station_a,
  input  logic [ert_pkg::STN_W-1:0]   in_station_b,
  input  logic [ert_pkg::ID_W-1:0]    in_edge_key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ert_pkg::ST_W-1:0]    out_status,
  output logic [ert_pkg::ID_W-1:0]    out_match_id,
  output logic [ert_pkg::STN_W-1:0]   out_from_station,
  output logic [ert_pkg::STN_W-1:0]   out_to_station,
  output logic [ert_pkg::CNT_W-1:0]   out_match_count,
  output logic                        out_last
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = 2;

  localparam logic [SW-1:0] S_IDLE   = 2'd0;
  localparam logic [SW-1:0] S_SCAN   = 2'd1;
  localparam logic [SW-1:0] S_FINISH = 2'd2;

  localparam logic [KEY_BITS-1:0] KEY_ONES = {KEY_BITS{1'b1}};

  logic [SW-1:0]               state_r, state_nxt;
  logic [CW-1:0]               count_r;
  logic [IW-1:0]               pos_r;
  logic [ert_pkg::OP_W-1:0]    op_r;
  logic [ert_pkg::STN_W-1:0]   sa_r, sb_r;
  logic [KEY_BITS-1:0]         key_r;
  logic                        found_r;
  logic [IW-1:0]               fpos_r;
  logic [ert_pkg::STN_W-1:0]   fstart_r, fend_r;
  logic [KEY_BITS-1:0]         max_r;
  logic [CW-1:0]               nmatch_r;

  logic                        out_valid_r;
  logic [ert_pkg::ST_W-1:0]    out_status_r;
  logic [ert_pkg::ID_W-1:0]    out_id_r;
  logic [ert_pkg::STN_W-1:0]   out_from_r, out_to_r;
  logic [ert_pkg::CNT_W-1:0]   out_count_r;
  logic                        out_last_r;

  logic [KEY_BITS-1:0]         c_id    [TABLE_DEPTH];
  logic [ert_pkg::STN_W-1:0]   c_start [TABLE_DEPTH];
  logic [ert_pkg::STN_W-1:0]   c_end   [TABLE_DEPTH];

  logic                        in_take, out_free;
  logic                        is_search, head_valid, hit, emit, step_en, fin_go;
  logic                        add_ok, rem_go;
  logic [KEY_BITS-1:0]         new_id;
  logic [KEY_BITS+ert_pkg::ID_W-1:0] key_ext;
  logic [ert_pkg::ID_W+KEY_BITS-1:0] head_id_ext, new_id_ext, key16_ext;
  logic [ert_pkg::CNT_W+CW-1:0]      nmatch_ext;

  ert_pkg::ert_cell_ctl_t      ctl [TABLE_DEPTH];

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign key_ext   = {{KEY_BITS{1'b0}}, in_edge_key};
  assign is_search = (op_r == ert_pkg::OP_FIND_FROM) || (op_r == ert_pkg::OP_FIND_TO) ||
                     (op_r == ert_pkg::OP_FIND_BETWEEN);
  assign head_valid = (CW'(pos_r) < count_r);

  always_comb begin
    case (op_r)
      ert_pkg::OP_FIND_FROM: hit = (c_start[0] == sa_r);
      ert_pkg::OP_FIND_TO:   hit = (c_end[0] == sa_r);
      default: hit = ((c_start[0] == sa_r) && (c_end[0] == sb_r)) ||
                     ((c_start[0] == sb_r) && (c_end[0] == sa_r));
    endcase
  end

  assign emit    = (state_r == S_SCAN) && is_search && head_valid && hit;
  assign step_en = (state_r == S_SCAN) && (!emit || out_free);
  assign fin_go  = (state_r == S_FINISH) && out_free;

  assign add_ok  = (op_r == ert_pkg::OP_ADD) && (count_r != CW'(TABLE_DEPTH)) &&
                   (max_r != KEY_ONES);
  assign rem_go  = fin_go && (op_r == ert_pkg::OP_REMOVE) && found_r;
  assign new_id  = max_r + 1'b1;

  assign head_id_ext = {{ert_pkg::ID_W{1'b0}}, c_id[0]};
  assign new_id_ext  = {{ert_pkg::ID_W{1'b0}}, new_id};
  assign key16_ext   = {{ert_pkg::ID_W{1'b0}}, key_r};
  assign nmatch_ext  = {{ert_pkg::CNT_W{1'b0}}, nmatch_r};

  // cell chain: cell i reads cell i+1, the top cell wraps to cell 0
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1) % TABLE_DEPTH;

    always_comb begin
      ctl[i].rotate  = step_en;
      ctl[i].compact = rem_go && (CW'(i) >= CW'(fpos_r)) && (CW'(i + 1) < count_r);
      ctl[i].load    = fin_go && add_ok && (count_r == CW'(i));
    end

    ert_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .nbr_id    (c_id[NXT]),
      .nbr_start (c_start[NXT]),
      .nbr_end   (c_end[NXT]),
      .new_id    (new_id),
      .new_start (sa_r),
      .new_end   (sb_r),
      .id_r      (c_id[i]),
      .start_r   (c_start[i]),
      .end_r     (c_end[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_opcode <= ert_pkg::OP_FIND_BETWEEN) state_nxt = S_SCAN;
          else                                       state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        if (step_en && (pos_r == IW'(TABLE_DEPTH - 1))) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go && add_ok) count_r <= count_r + 1'b1;
      else if (rem_go)      count_r <= count_r - 1'b1;
      if (emit && step_en || fin_go) out_valid_r <= 1'b1;
      else if (!out_stall)           out_valid_r <= 1'b0;
    end
  end

  // operation context and scan accumulators
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r     <= in_opcode;
      sa_r     <= in_station_a;
      sb_r     <= in_station_b;
      key_r    <= key_ext[KEY_BITS-1:0];
      pos_r    <= '0;
      found_r  <= 1'b0;
      max_r    <= '0;
      nmatch_r <= '0;
    end else if (step_en) begin
      pos_r <= IW'(pos_r + 1'b1);
      if (head_valid) begin
        if (c_id[0] > max_r) max_r <= c_id[0];
        if (!found_r && (c_id[0] == key_r)) begin
          found_r  <= 1'b1;
          fpos_r   <= pos_r;
          fstart_r <= c_start[0];
          fend_r   <= c_end[0];
        end
      end
      if (emit) nmatch_r <= nmatch_r + 1'b1;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (emit && step_en) begin
      out_status_r <= ert_pkg::ST_OK;
      out_id_r     <= head_id_ext[ert_pkg::ID_W-1:0];
      out_from_r   <= '0;
      out_to_r     <= '0;
      out_count_r  <= '0;
      out_last_r   <= 1'b0;
    end else if (fin_go) begin
      out_from_r  <= '0;
      out_to_r    <= '0;
      out_count_r <= '0;
      out_last_r  <= 1'b1;
      out_id_r    <= '0;
      unique case (op_r) inside
        ert_pkg::OP_ADD: begin
          if (count_r == CW'(TABLE_DEPTH)) begin
            out_status_r <= ert_pkg::ST_FULL;
          end else if (max_r == KEY_ONES) begin
            out_status_r <= ert_pkg::ST_EXHAUSTED;
          end else begin
            out_status_r <= ert_pkg::ST_OK;
            out_id_r     <= new_id_ext[ert_pkg::ID_W-1:0];
          end
        end
        ert_pkg::OP_REMOVE, ert_pkg::OP_LOOKUP: begin
          out_status_r <= found_r ? ert_pkg::ST_OK : ert_pkg::ST_NOT_FOUND;
          out_id_r     <= key16_ext[ert_pkg::ID_W-1:0];
          if (found_r && (op_r == ert_pkg::OP_LOOKUP)) begin
            out_from_r <= fstart_r;
            out_to_r   <= fend_r;
          end
        end
        ert_pkg::OP_FIND_FROM, ert_pkg::OP_FIND_TO, ert_pkg::OP_FIND_BETWEEN: begin
          out_status_r <= ert_pkg::ST_OK;
          out_count_r  <= nmatch_ext[ert_pkg::CNT_W-1:0];
        end
        default: begin
          out_status_r <= ert_pkg::ST_NOT_FOUND;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_id     = out_id_r;
  assign out_from_station = out_from_r;
  assign out_to_station   = out_to_r;
  assign out_match_count  = out_count_r;
  assign out_last         = out_last_r;

endmodule
